/* rtl/esc_pkg.sv */
// Shared types, constants and helpers for the epoch seconds to calendar block.
// Used by the controller, the datapath and the top level.
package esc_pkg;

	// Fixed field widths
	localparam int EPOCH_W = 32;
	localparam int OFFSET_W = 5;
	localparam int SEC_W = 33;
	localparam int MUL_A_W = 26;
	localparam int RECIP_W = 27;
	localparam int PROD_W = 53;
	localparam int REM_W = 17;
	localparam int DAYS_W = 16;
	localparam int YEAR_W = 12;

	// Split by constants: 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15. The power of two
	// is dropped as low bits, the odd part is divided by a rounded-up reciprocal that is
	// exact over the whole dividend range (product shifted right by 36, 21 and 14 bits).
	localparam logic [RECIP_W-1:0] DAY_RECIP = 27'd101806633;
	localparam logic [RECIP_W-1:0] HOUR_RECIP = 27'd9321;
	localparam logic [RECIP_W-1:0] MIN_RECIP = 27'd1093;
	localparam logic [25:0] DAY_ODD = 26'd675;
	localparam logic [12:0] HOUR_ODD = 13'd225;
	localparam logic [9:0]  MIN_ODD = 10'd15;

	// Calendar constants
	localparam logic [YEAR_W-1:0] BASE_YEAR = 12'd1970;
	localparam logic [YEAR_W-1:0] SKIP_LEAP_YEAR = 12'd2100;
	localparam logic [DAYS_W-1:0] QUAD_DAYS = 16'd1461;
	localparam logic [DAYS_W-1:0] YEAR_DAYS = 16'd365;
	localparam logic [DAYS_W-1:0] LEAP_YEAR_DAYS = 16'd366;
	localparam logic [3:0] LAST_MONTH = 4'd11;
	localparam logic [3:0] FEB_INDEX = 4'd1;
	localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = 5'sd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAY,
		ST_HOUR,
		ST_MIN,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} esc_state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_SPLIT,
		OP_YEAR,
		OP_MONTH
	} dp_op_t;

	typedef enum logic [1:0] {
		DIV_DAY,
		DIV_HOUR,
		DIV_MIN
	} div_sel_t;

	typedef struct packed {
		dp_op_t   op;
		div_sel_t div_sel;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic year_done;
		logic month_done;
		logic out_busy;
	} dp_stat_t;

	// Length of a month, index 0 is January
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
			4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
			FEB_INDEX: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

/* rtl/esc_in_if.sv */
// Input channel: one beat carries a 32-bit count of seconds since the epoch.
// Standalone interface, no dependencies.
interface esc_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink (input valid, input epoch_seconds, output ready);
endinterface

/* rtl/esc_out_if.sv */
// Output channel: one beat carries the local calendar date and time.
// Standalone interface, no dependencies.
interface esc_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic        clamped;

	modport source (output valid, output year, output month, output day, output hour,
		output minute, output second, output clamped, input ready);
	modport sink (input valid, input year, input month, input day, input hour,
		input minute, input second, input clamped, output ready);
endinterface

/* rtl/esc_dp.sv */
// Datapath: zone shift, reciprocal-multiply splits into days, hours and minutes, year and
// month walks, output register. Depends on esc_pkg and esc_out_if.
module esc_dp import esc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic signed [OFFSET_W-1:0] cfg_wdata,
	input  logic [EPOCH_W-1:0]         epoch_seconds,
	input  dp_cmd_t                    cmd,
	output dp_stat_t                   stat,
	esc_out_if.source                  cal
);

	logic signed [OFFSET_W-1:0] zone_q;
	logic [SEC_W-1:0]  sec_q;
	logic [PROD_W-1:0] prod_q;
	logic [REM_W-1:0]  rem_q;
	logic [DAYS_W-1:0] days_q;
	logic [4:0]        hour_q;
	logic [5:0]        minute_q;
	logic [5:0]        second_q;
	logic [YEAR_W-1:0] year_q;
	logic [3:0]        month_q;
	logic              clamp_q;
	logic              out_valid_q;

	logic signed [16:0]  off_sec;
	logic signed [33:0]  shifted;
	logic [MUL_A_W-1:0]  mul_a;
	logic [RECIP_W-1:0]  mul_b;
	logic [PROD_W-1:0]   product;
	logic [DAYS_W-1:0]   day_quot;
	logic [25:0]         day_back;
	logic [25:0]         day_rem;
	logic [4:0]          hour_quot;
	logic [12:0]         hour_back;
	logic [12:0]         hour_rem;
	logic [5:0]          min_quot;
	logic [9:0]          min_back;
	logic [9:0]          min_rem;
	logic                leap;
	logic [DAYS_W-1:0]   year_len;
	logic                quad_jump;
	logic [DAYS_W-1:0]   mon_len;

	// Hold the zone offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			zone_q <= cfg_wdata;
		end
	end

	// Shift by the zone offset in seconds
	always_comb begin
		off_sec = 17'(zone_q) * 17'sd3600;
		shifted = $signed({2'b00, epoch_seconds}) + 34'(off_sec);
	end

	// Shared multiplier: dividend with its power-of-two part dropped, times the reciprocal
	always_comb begin
		case (cmd.div_sel)
			DIV_DAY: begin
				mul_a = sec_q[32:7];
				mul_b = DAY_RECIP;
			end
			DIV_HOUR: begin
				mul_a = 26'(rem_q[16:4]);
				mul_b = HOUR_RECIP;
			end
			DIV_MIN: begin
				mul_a = 26'(rem_q[11:2]);
				mul_b = MIN_RECIP;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		product = {27'b0, mul_a} * {26'b0, mul_b};
	end

	// Quotients from the registered product, remainders by multiply back and subtract
	always_comb begin
		day_quot = prod_q[51:36];
		day_back = 26'(day_quot) * DAY_ODD;
		day_rem = sec_q[32:7] - day_back;
		hour_quot = prod_q[25:21];
		hour_back = 13'(hour_quot) * HOUR_ODD;
		hour_rem = rem_q[16:4] - hour_back;
		min_quot = prod_q[19:14];
		min_back = 10'(min_quot) * MIN_ODD;
		min_rem = rem_q[11:2] - min_back;
	end

	// Year and month lengths; the only century in range that skips its leap day is 2100
	always_comb begin
		leap = (year_q[1:0] == 2'b00) && (year_q != SKIP_LEAP_YEAR);
		year_len = leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
		quad_jump = (year_q[1:0] == 2'b00) && (year_q != SKIP_LEAP_YEAR)
			&& (days_q >= QUAD_DAYS);
		mon_len = DAYS_W'(month_days(month_q, leap));
		stat.year_done = !quad_jump && (days_q < year_len);
		stat.month_done = (month_q == LAST_MONTH) || (days_q < mon_len);
		stat.out_busy = out_valid_q && !cal.ready;
	end

	// Work registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				if (shifted[33]) begin
					sec_q <= '0;
					clamp_q <= 1'b1;
				end else begin
					sec_q <= shifted[SEC_W-1:0];
					clamp_q <= 1'b0;
				end
			end
			OP_MUL: begin
				prod_q <= product;
			end
			OP_SPLIT: begin
				case (cmd.div_sel)
					DIV_DAY: begin
						days_q <= day_quot;
						rem_q <= {day_rem[9:0], sec_q[6:0]};
					end
					DIV_HOUR: begin
						hour_q <= hour_quot;
						rem_q <= {5'b0, hour_rem[7:0], rem_q[3:0]};
					end
					DIV_MIN: begin
						minute_q <= min_quot;
						second_q <= {min_rem[3:0], rem_q[1:0]};
						year_q <= BASE_YEAR;
						month_q <= '0;
					end
					default: begin
					end
				endcase
			end
			OP_YEAR: begin
				if (quad_jump) begin
					days_q <= days_q - QUAD_DAYS;
					year_q <= year_q + 12'd4;
				end else begin
					days_q <= days_q - year_len;
					year_q <= year_q + 12'd1;
				end
			end
			OP_MONTH: begin
				days_q <= days_q - mon_len;
				month_q <= month_q + 4'd1;
			end
			default: begin
			end
		endcase
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (cal.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cal.year <= year_q;
			cal.month <= month_q + 4'd1;
			cal.day <= days_q[4:0] + 5'd1;
			cal.hour <= hour_q;
			cal.minute <= minute_q;
			cal.second <= second_q;
			cal.clamped <= clamp_q;
		end
	end

	assign cal.valid = out_valid_q;

endmodule

/* rtl/esc_ctrl.sv */
// Controller: sequences load, the three multiply-and-split steps, year walk, month walk
// and output. Depends on esc_pkg.
module esc_ctrl import esc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	esc_state_t state_q, state_d;
	logic split_q, split_d;

	// State and split phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			split_q <= 1'b0;
		end else begin
			state_q <= state_d;
			split_q <= split_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		split_d = split_q;
		in_ready = 1'b0;
		cmd.op = OP_NONE;
		cmd.div_sel = DIV_DAY;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					split_d = 1'b0;
					state_d = ST_DAY;
				end
			end
			ST_DAY: begin
				cmd.div_sel = DIV_DAY;
				if (split_q) begin
					cmd.op = OP_SPLIT;
					split_d = 1'b0;
					state_d = ST_HOUR;
				end else begin
					cmd.op = OP_MUL;
					split_d = 1'b1;
				end
			end
			ST_HOUR: begin
				cmd.div_sel = DIV_HOUR;
				if (split_q) begin
					cmd.op = OP_SPLIT;
					split_d = 1'b0;
					state_d = ST_MIN;
				end else begin
					cmd.op = OP_MUL;
					split_d = 1'b1;
				end
			end
			ST_MIN: begin
				cmd.div_sel = DIV_MIN;
				if (split_q) begin
					cmd.op = OP_SPLIT;
					split_d = 1'b0;
					state_d = ST_YEAR;
				end else begin
					cmd.op = OP_MUL;
					split_d = 1'b1;
				end
			end
			ST_YEAR: begin
				if (stat.year_done) begin
					state_d = ST_MONTH;
				end else begin
					cmd.op = OP_YEAR;
				end
			end
			ST_MONTH: begin
				if (stat.month_done) begin
					state_d = ST_DONE;
				end else begin
					cmd.op = OP_MONTH;
				end
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/epoch_seconds_to_calendar.sv */
// Epoch seconds to local calendar date. From input beat to result valid, the block runs
// the day, hour and minute splits (each a multiply, then a remainder), up to 40 year
// steps (four-year jumps), up to 11 month steps, a step to leave each walk and a load of
// the output, which waits while the output is stalled. One item at a time; the next beat
// is taken in the cycle after the result is loaded, while the result waits on output.
// Reset (arst_n low, asynchronous) idles the controller, drops output valid and sets
// the zone offset to 8 hours.
module epoch_seconds_to_calendar import esc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic signed [OFFSET_W-1:0] cfg_wdata,
	esc_in_if.sink                     epoch,
	esc_out_if.source                  cal
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_ready;

	// Accept beats only from the controller's idle state
	assign epoch.ready = in_ready;

	esc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (epoch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	esc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.epoch_seconds (epoch.epoch_seconds),
		.cmd           (cmd),
		.stat          (stat),
		.cal           (cal)
	);

endmodule

/* dv/tb_epoch_seconds_to_calendar.sv */
`timescale 1ns / 1ps
// Testbench for epoch_seconds_to_calendar: directed calendar and zone corner cases, then
// random seconds under several zone offsets and handshake idling patterns.
// Depends on esc_pkg, esc_in_if, esc_out_if and the RTL top level.
module tb_epoch_seconds_to_calendar;
	import esc_pkg::*;

	typedef struct {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        clamped;
	} calendar_t;

	localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int SECS_PER_ZONE_HOUR = 3600;
	localparam int RANDOM_PER_ZONE = 50;
	localparam int SETTLE_CYCLES = 130;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic signed [OFFSET_W-1:0] cfg_wdata;

	esc_in_if  epoch_ch ();
	esc_out_if cal_ch ();

	epoch_seconds_to_calendar dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.epoch     (epoch_ch),
		.cal       (cal_ch)
	);

	// Zone offset as the block should hold it, and the dates still owed by it
	logic signed [OFFSET_W-1:0] zone_now = OFFSET_RESET;
	calendar_t calendar_due [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_count = 0;
	int beats_sent = 0;
	int dates_checked = 0;
	int clamps_seen = 0;
	int zone_writes = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Local calendar date of a UTC second count under a signed hour offset
	function automatic calendar_t local_date(input logic [31:0] secs,
		input logic signed [OFFSET_W-1:0] zone);
		calendar_t r;
		longint shifted;
		longint days;
		int yr;
		int mo;
		int span;
		bit leap;
		shifted = longint'(secs) + longint'(zone) * SECS_PER_ZONE_HOUR;
		r.clamped = (shifted < 0);
		if (shifted < 0)
			shifted = 0;
		r.second = 6'(shifted % 60);
		shifted = shifted / 60;
		r.minute = 6'(shifted % 60);
		shifted = shifted / 60;
		r.hour = 5'(shifted % 24);
		days = shifted / 24;
		// Walk whole years, then months of the final year
		yr = 1970;
		forever begin
			leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
			span = leap ? 366 : 365;
			if (days < span)
				break;
			days -= span;
			yr++;
		end
		mo = 0;
		while (mo < 11) begin
			span = MONTH_LEN[mo] + ((mo == 1 && leap) ? 1 : 0);
			if (days < span)
				break;
			days -= span;
			mo++;
		end
		r.year = 12'(yr);
		r.month = 4'(mo + 1);
		r.day = 5'(days + 1);
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endfunction

	// Randomize receiver back-pressure every cycle
	always @(negedge clk) begin
		cal_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Compare each accepted date against the oldest one owed
	always @(posedge clk) begin : date_check
		calendar_t want;
		if (cal_ch.valid && cal_ch.ready) begin
			if (calendar_due.size() == 0) begin
				$error("date beat with none owed: %0d-%0d-%0d %0d:%0d:%0d", cal_ch.year,
					cal_ch.month, cal_ch.day, cal_ch.hour, cal_ch.minute, cal_ch.second);
				err_count++;
			end else begin
				want = calendar_due.pop_front();
				check_field("year", want.year, cal_ch.year);
				check_field("month", want.month, cal_ch.month);
				check_field("day", want.day, cal_ch.day);
				check_field("hour", want.hour, cal_ch.hour);
				check_field("minute", want.minute, cal_ch.minute);
				check_field("second", want.second, cal_ch.second);
				check_field("clamped", want.clamped, cal_ch.clamped);
				dates_checked++;
			end
		end
	end

	// Offer one beat, record its date at acceptance; entered and left at a falling edge
	task automatic send_seconds(input logic [31:0] secs);
		calendar_t due;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			epoch_ch.valid <= 1'b0;
			@(negedge clk);
		end
		epoch_ch.valid <= 1'b1;
		epoch_ch.epoch_seconds <= secs;
		@(posedge clk);
		while (!epoch_ch.ready)
			@(posedge clk);
		due = local_date(secs, zone_now);
		if (due.clamped)
			clamps_seen++;
		calendar_due.push_back(due);
		beats_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed date has come back
	task automatic drain;
		epoch_ch.valid <= 1'b0;
		while (calendar_due.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Write the zone offset; only called with the block idle
	task automatic write_zone(input logic signed [OFFSET_W-1:0] zone);
		cfg_we <= 1'b1;
		cfg_wdata <= zone;
		zone_now = zone;
		zone_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_seconds;
		longint day_start;
		day_start = longint'($urandom_range(0, 49710)) * 86400;
		case ($urandom_range(0, 9))
			5, 6: return $urandom_range(0, 120000);
			7: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
			8, 9: return 32'(day_start + $urandom_range(0, 2) - 1);
			default: return $urandom;
		endcase
	endfunction

	// Reset offset of 8 hours: extremes of the input
	task automatic test_reset_zone;
		send_seconds(32'd0);
		send_seconds(32'hFFFF_FFFF);
		send_seconds(32'h8000_0000);
		send_seconds(32'h7FFF_FFFF);
		drain();
	endtask

	// UTC: year ends, leap days of 1972 and 2000, and the skipped leap day of 2100
	task automatic test_calendar_edges;
		write_zone(OFFSET_W'(0));
		send_seconds(32'd31535999);
		send_seconds(32'd68169600);
		send_seconds(32'd94694399);
		send_seconds(32'd946684799);
		send_seconds(32'd946684800);
		send_seconds(32'd951782399);
		send_seconds(32'd951782400);
		send_seconds(32'd951868800);
		send_seconds(32'd4107542399);
		send_seconds(32'd4107542400);
		drain();
	endtask

	// Offsets at both ends of the 5-bit range and the working range: clamp edges, top date
	task automatic test_zone_extremes;
		write_zone(-5'sd16);
		send_seconds(32'd0);
		send_seconds(32'd57599);
		send_seconds(32'd57600);
		send_seconds(32'hFFFF_FFFF);
		drain();
		write_zone(-5'sd12);
		send_seconds(32'd43199);
		send_seconds(32'd43200);
		drain();
		write_zone(5'sd15);
		send_seconds(32'd0);
		send_seconds(32'hFFFF_FFFF);
		drain();
		write_zone(5'sd14);
		send_seconds(32'hFFFF_FFFF);
		drain();
	endtask

	// Random seconds under each zone, across the idling patterns
	task automatic test_random_zones;
		logic signed [OFFSET_W-1:0] zones [6];
		int send_pct [4];
		int recv_pct [4];
		send_pct = '{0, 74, 0, 18};
		recv_pct = '{0, 0, 74, 18};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pct[ph];
			recv_stall_pct = recv_pct[ph];
			zones = '{-5'sd12, 5'sd14, -5'sd16, 5'sd15, 5'sd0, OFFSET_W'($urandom)};
			for (int z = 0; z < 6; z++) begin
				write_zone(zones[z]);
				repeat (RANDOM_PER_ZONE)
					send_seconds(pick_seconds());
				drain();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		epoch_ch.valid = 1'b0;
		epoch_ch.epoch_seconds = '0;
		cal_ch.ready = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_zone();
		test_calendar_edges();
		test_zone_extremes();
		test_random_zones();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("Converted %0d second counts, checked %0d dates (%0d clamped), %0d zone writes.",
			beats_sent, dates_checked, clamps_seen, zone_writes);
		$display("Idling covered none, sender only, receiver only and both; %0d errors.",
			err_count);
		if (err_count == 0 && calendar_due.size() == 0)
			$display("** epoch_seconds_to_calendar: PASSED **");
		else
			$display("** epoch_seconds_to_calendar: FAILED **");
		$finish;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#20_000_000;
		$display("Timed out with %0d dates still owed.", calendar_due.size());
		$display("** epoch_seconds_to_calendar: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
rtl/esc_pkg.sv
rtl/esc_in_if.sv
rtl/esc_out_if.sv
rtl/esc_dp.sv
rtl/esc_ctrl.sv
rtl/epoch_seconds_to_calendar.sv
dv/tb_epoch_seconds_to_calendar.sv
